// ===== rtl/core/sm4_pkg.sv =====
// Shared constants and round functions for the SM4 block cipher.
`timescale 1ns / 1ps
package sm4_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 2'd2;

  localparam logic [BLOCK_W-1:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef logic [WORD_W-1:0] word_t;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic word_t sub_word(word_t x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic word_t round_t(word_t x);
    word_t b;
    b = sub_word(x);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic word_t key_t(word_t x);
    word_t b;
    b = sub_word(x);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic word_t ck_word(logic [7:0] i);
    word_t w;
    logic [7:0] base;
    w = '0;
    base = {i[5:0], 2'b00};
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/sm4_key_sched.sv =====
// Iterative SM4 key expansion that fills the round key registers.
`timescale 1ns / 1ps
module sm4_key_sched #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sm4_pkg::BLOCK_W-1:0] key_i,
  output logic                       busy_o,
  output sm4_pkg::word_t             rk_o [ROUNDS]
);
  import sm4_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROUNDS);

  logic             run_q;
  logic [CNT_W-1:0] cnt_q;
  word_t            k_q [4];
  word_t            rk_q [ROUNDS];
  word_t            nk;

  assign nk     = k_q[0] ^ key_t(k_q[1] ^ k_q[2] ^ k_q[3] ^ ck_word(8'(cnt_q)));
  assign busy_o = start_i || run_q;
  assign rk_o   = rk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      if (cnt_q == CNT_W'(ROUNDS - 1)) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      k_q[0] <= key_i[127:96] ^ FK[127:96];
      k_q[1] <= key_i[95:64]  ^ FK[95:64];
      k_q[2] <= key_i[63:32]  ^ FK[63:32];
      k_q[3] <= key_i[31:0]   ^ FK[31:0];
    end else if (run_q) begin
      k_q[0]      <= k_q[1];
      k_q[1]      <= k_q[2];
      k_q[2]      <= k_q[3];
      k_q[3]      <= nk;
      rk_q[cnt_q] <= nk;
    end
  end

endmodule

// ===== rtl/core/sm4_round_cell.sv =====
// One SM4 round with its pipeline register.
`timescale 1ns / 1ps
module sm4_round_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [sm4_pkg::BLOCK_W-1:0] data_i,
  input  sm4_pkg::word_t              rk_i,
  output logic                        valid_o,
  output logic [sm4_pkg::BLOCK_W-1:0] data_o
);
  import sm4_pkg::*;

  logic               valid_q;
  logic [BLOCK_W-1:0] data_q;
  logic [BLOCK_W-1:0] data_d;
  word_t              nx;

  assign nx     = data_i[127:96] ^ round_t(data_i[95:64] ^ data_i[63:32] ^ data_i[31:0] ^ rk_i);
  assign data_d = {data_i[95:0], nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/sm4_block_cipher.sv =====
// SM4 block cipher top level: configuration, key expansion and round pipeline.
// Usage:
//   Write key_high (index 0), key_low (index 1) and decrypt_mode (index 2) on the
//   cfg channel while the block is idle; cfg_ready_o is always high.
//   A key write starts the key expansion, which holds in_stall_o high while it
//   runs. After reset the expansion of the all-zero key runs the same way
//   before the first block is taken.
//   Each input transfer carries one 128-bit block; each output transfer carries
//   the ciphered block, in input order.
//   An input transfer reaches the outputs through ROUNDS round cells, one round
//   and one pipeline register per cell. Throughput is one block per cycle
//   while out_stall_i is low and no key expansion is running.
//   When out_stall_i is high with a result waiting, the whole chain holds and
//   in_stall_o goes high in the same cycle; the result stays on the outputs.
`timescale 1ns / 1ps
module sm4_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sm4_pkg::HALF_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sm4_pkg::HALF_W-1:0]    block_high_i,
  input  logic [sm4_pkg::HALF_W-1:0]    block_low_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sm4_pkg::HALF_W-1:0]    result_high_o,
  output logic [sm4_pkg::HALF_W-1:0]    result_low_o
);
  import sm4_pkg::*;

  logic [HALF_W-1:0]  key_high_q;
  logic [HALF_W-1:0]  key_low_q;
  logic               decrypt_q;
  logic               start_q;
  logic               start_d;
  logic               key_busy;
  logic               pipe_en;
  logic               cfg_we;
  word_t              rk [ROUNDS];
  logic               valid_s [ROUNDS+1];
  logic [BLOCK_W-1:0] data_s  [ROUNDS+1];

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign start_d     = cfg_we && (cfg_index_i == REG_KEY_HIGH || cfg_index_i == REG_KEY_LOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      decrypt_q  <= 1'b0;
      start_q    <= 1'b1;
    end else begin
      start_q <= start_d;
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_KEY_HIGH: key_high_q <= cfg_data_i;
          REG_KEY_LOW:  key_low_q  <= cfg_data_i;
          REG_DECRYPT:  decrypt_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  sm4_key_sched #(
    .ROUNDS(ROUNDS)
  ) u_key_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .key_i  ({key_high_q, key_low_q}),
    .busy_o (key_busy),
    .rk_o   (rk)
  );

  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = key_busy || !pipe_en;

  assign valid_s[0] = in_valid_i && !in_stall_o;
  assign data_s[0]  = {block_high_i, block_low_i};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    sm4_round_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .valid_i(valid_s[g]),
      .data_i (data_s[g]),
      .rk_i   (decrypt_q ? rk[ROUNDS-1-g] : rk[g]),
      .valid_o(valid_s[g+1]),
      .data_o (data_s[g+1])
    );
  end

  assign out_valid_o   = valid_s[ROUNDS];
  assign result_high_o = {data_s[ROUNDS][31:0], data_s[ROUNDS][63:32]};
  assign result_low_o  = {data_s[ROUNDS][95:64], data_s[ROUNDS][127:96]};

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_busy |-> in_stall_o) else $error("input taken during key expansion");

  a_key_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_d |=> key_busy) else $error("key write did not start expansion");

  a_out_hold_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o) else $error("input taken while output held");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_high_o)))
    else $error("held result changed");

endmodule
